>>> rtl/core/bblur_pkg.sv
// Package for the edge-aware 3x3 box blur: sizes, codes, item types and the
// reciprocal table used for the rounded division. No dependencies.
package bblur_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;

    localparam int COL_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int IN_ROW_W     = $clog2(MAX_HEIGHT + 3);
    localparam int OUT_ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam int CH_W         = 8;
    localparam int PIX_W        = 3 * CH_W;
    localparam int LINE_W       = 2 * PIX_W;
    localparam int SUM_W        = 12;
    localparam int CNT_W        = 4;
    localparam int NUM_W        = SUM_W + 1;
    localparam int RECIP_SHIFT  = 17;
    localparam int RECIP_W      = 17;
    localparam int PROD_W       = NUM_W + RECIP_W;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic          command;
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic          frame_last;
    } out_item_t;

    // ceil(2^17 / (2*count)); exact for every numerator 2*sum+count that can occur.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        begin
            case (cnt)
                CNT_W'(1): m = RECIP_W'(65536);
                CNT_W'(2): m = RECIP_W'(32768);
                CNT_W'(3): m = RECIP_W'(21846);
                CNT_W'(4): m = RECIP_W'(16384);
                CNT_W'(6): m = RECIP_W'(10923);
                CNT_W'(9): m = RECIP_W'(7282);
                default:   m = RECIP_W'(65536);
            endcase
            return m;
        end
    endfunction

endpackage

>>> rtl/core/bblur_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// A read of the address being written returns the old data. No dependencies.
module bblur_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/box_blur_3x3_edge_aware.sv
// Top level of the edge-aware 3x3 box blur over a raster RGB stream.
// Depends on bblur_pkg and the line store RAM bblur_ram.
//
//   channel  handshake                 payload      direction
//   src      src_valid / src_stall     in_item_t    into the block
//   dst      dst_valid / dst_stall     out_item_t   out of the block
//   cfg      cfg_write                 cfg_index, cfg_data (13 bits)
//
// The block takes one item per clock while src_stall is low. A result passes the
// registers s1, s2, s3 and the output register; the single line store RAM is read
// when an item enters and written back when that item moves on out of s1.
// Reset clears the counters, the window and the pipeline; the line store needs no
// clearing. A stalled output holds its item while earlier stages fill their bubbles.
module box_blur_3x3_edge_aware
    import bblur_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   src_valid,
    output logic                   src_stall,
    input  in_item_t               src_item,
    output logic                   dst_valid,
    input  logic                   dst_stall,
    output out_item_t              dst_item,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic                    cfg_hit;

    logic [COL_W-1:0]     in_col_reg, in_col_next;
    logic [IN_ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;

    logic             accept;
    logic             in_frame;
    logic             has_res;
    logic             out_top, out_bot, out_left, out_right, pos_last;
    logic [1:0]       rows_n, cols_n;
    logic [8:0]       mask;
    logic [PIX_W-1:0] px;

    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg, dst_valid_reg;
    logic             s1_ready, s2_ready, s3_ready, out_ready;
    logic             s1_adv;
    logic [PIX_W-1:0] s1_px_reg;
    logic [COL_W-1:0] s1_ic_reg;
    logic             s1_res_reg, s1_last_reg;
    logic [8:0]       s1_mask_reg;
    logic [CNT_W-1:0] s1_cnt_reg;

    logic [LINE_W-1:0] rd_line;
    logic              fwd_reg;
    logic [PIX_W-1:0]  fwd_up_reg, fwd_mid_reg;
    logic [PIX_W-1:0]  up_eff, mid_eff;

    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] win_new [9];

    logic [PIX_W-1:0] s2_win_reg [9];
    logic [8:0]       s2_mask_reg;
    logic [CNT_W-1:0] s2_cnt_reg;
    logic             s2_last_reg;

    logic [SUM_W-1:0] sum [3];
    logic [NUM_W-1:0] s3_num_reg [3];
    logic [RECIP_W-1:0] s3_recip_reg;
    logic             s3_last_reg;

    logic [PROD_W-1:0] prod [3];
    out_item_t         dst_item_reg;

    // Effective frame size.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WIDTH_REG_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = HEIGHT_REG_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign cfg_hit = cfg_write && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    // Handshake chain: each stage moves when the next one is empty or moving.
    assign out_ready = !dst_valid_reg || !dst_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign src_stall = !s1_ready;
    assign accept    = src_valid && s1_ready;
    assign s1_adv    = s1_valid_reg && s2_ready;

    // Position logic at the entry.
    always_comb
    begin
        in_frame  = 32'(in_row_reg) < 32'(h_eff);
        has_res   = !((in_row_reg == '0) ||
                      (in_row_reg == IN_ROW_W'(1) && in_col_reg == '0));
        out_top   = (out_row_reg == '0);
        out_bot   = (32'(out_row_reg) + 32'd1 >= 32'(h_eff));
        out_left  = (out_col_reg == '0);
        out_right = (32'(out_col_reg) + 32'd1 >= 32'(w_eff));
        pos_last  = out_bot && out_right;
        rows_n    = 2'd1 + 2'(!out_top) + 2'(!out_bot);
        cols_n    = 2'd1 + 2'(!out_left) + 2'(!out_right);
        mask[0] = !out_top && !out_left;
        mask[1] = !out_top;
        mask[2] = !out_top && !out_right;
        mask[3] = !out_left;
        mask[4] = 1'b1;
        mask[5] = !out_right;
        mask[6] = !out_bot && !out_left;
        mask[7] = !out_bot;
        mask[8] = !out_bot && !out_right;
        if (src_item.command == CMD_PIXEL && in_frame)
            px = {src_item.in_red, src_item.in_green, src_item.in_blue};
        else
            px = '0;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_hit || (accept && has_res && pos_last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (32'(in_col_reg) + 32'd1 >= 32'(w_eff))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IN_ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (has_res)
            begin
                if (out_right)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OUT_ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Line store: upper row in the high half, middle row in the low half.
    bblur_ram #(
        .DATA_W (LINE_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_ic_reg),
        .wr_data ({mid_eff, s1_px_reg}),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .rd_data (rd_line)
    );

    // When the previous item wrote the same entry in the cycle of the read,
    // its write data replaces the stale read data.
    always_comb
    begin
        up_eff  = fwd_reg ? fwd_up_reg  : rd_line[LINE_W-1:PIX_W];
        mid_eff = fwd_reg ? fwd_mid_reg : rd_line[PIX_W-1:0];
        for (int r = 0; r < 3; r++)
        begin
            win_new[r*3]     = win_reg[r*3 + 1];
            win_new[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_new[2] = up_eff;
        win_new[5] = mid_eff;
        win_new[8] = s1_px_reg;
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = '0;
            for (int k = 0; k < 9; k++)
            begin
                if (s2_mask_reg[k])
                    sum[c] = sum[c] + SUM_W'(s2_win_reg[k][PIX_W-1-c*CH_W -: CH_W]);
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            prod[c] = PROD_W'(s3_num_reg[c]) * PROD_W'(s3_recip_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_REG_W'(640);
            height_reg    <= HEIGHT_REG_W'(480);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            dst_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_write && cfg_index == REG_IMAGE_WIDTH)
                width_reg <= cfg_data[WIDTH_REG_W-1:0];
            if (cfg_write && cfg_index == REG_IMAGE_HEIGHT)
                height_reg <= cfg_data[HEIGHT_REG_W-1:0];
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            s1_valid_reg  <= accept || (s1_valid_reg && !s2_ready);
            s2_valid_reg  <= (s1_adv && s1_res_reg) || (s2_valid_reg && !s3_ready);
            s3_valid_reg  <= (s2_valid_reg && s3_ready) || (s3_valid_reg && !out_ready);
            dst_valid_reg <= (s3_valid_reg && out_ready) || (dst_valid_reg && dst_stall);
            if (accept)
                fwd_reg <= s1_valid_reg && (s1_ic_reg == in_col_reg);
            for (int k = 0; k < 9; k++)
            begin
                if (cfg_hit || (s1_adv && s1_last_reg))
                    win_reg[k] <= '0;
                else if (s1_adv)
                    win_reg[k] <= win_new[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= px;
            s1_ic_reg   <= in_col_reg;
            s1_res_reg  <= has_res;
            s1_last_reg <= has_res && pos_last;
            s1_mask_reg <= mask;
            s1_cnt_reg  <= CNT_W'(rows_n) * CNT_W'(cols_n);
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= s1_px_reg;
        end
        if (s1_adv && s1_res_reg)
        begin
            for (int k = 0; k < 9; k++)
            begin
                s2_win_reg[k] <= win_new[k];
            end
            s2_mask_reg <= s1_mask_reg;
            s2_cnt_reg  <= s1_cnt_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_valid_reg && s3_ready)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s3_num_reg[c] <= {sum[c], 1'b0} + NUM_W'(s2_cnt_reg);
            end
            s3_recip_reg <= recip(s2_cnt_reg);
            s3_last_reg  <= s2_last_reg;
        end
        if (s3_valid_reg && out_ready)
        begin
            dst_item_reg.out_red    <= prod[0][RECIP_SHIFT +: CH_W];
            dst_item_reg.out_green  <= prod[1][RECIP_SHIFT +: CH_W];
            dst_item_reg.out_blue   <= prod[2][RECIP_SHIFT +: CH_W];
            dst_item_reg.frame_last <= s3_last_reg;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_item  = dst_item_reg;

endmodule
